>>> rtl/page_framebuffer_draw_engine_assert.svh
// Assertion macros used by the draw engine back end.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define PFDE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFDE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pfde_pkg.sv
// Package of the page frame store draw engine: command codes, register indexes,
// field widths, the decoded command, geometry and status records. No dependencies.
`timescale 1ns / 1ps
package pfde_pkg;

    localparam logic [2:0] CMD_PIXEL    = 3'd0;
    localparam logic [2:0] CMD_RD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_FILL     = 3'd2;
    localparam logic [2:0] CMD_OUTLINE  = 3'd3;
    localparam logic [2:0] CMD_BITMAP   = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;
    localparam logic [2:0] CMD_INVERT   = 3'd6;
    localparam logic [2:0] CMD_RD_BYTE  = 3'd7;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam int ADDR_W = 12;   // store address, up to 4096 bytes
    localparam int XW     = 9;    // x inside the frame, up to 256
    localparam int YW     = 7;    // y inside the frame, up to 128
    localparam int ACT_W  = 13;   // active byte count, up to 4096

    typedef struct packed {
        logic [8:0]  w;
        logic [7:0]  h;
        logic [ACT_W-1:0] active;
    } pfde_geom_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic              color;
        logic              ok;
        logic              empty;
        logic              left_on;
        logic              right_on;
        logic              top_on;
        logic              bot_on;
        logic [7:0]        bm_mask;
        logic [2:0]        bit_sel;
        logic [ADDR_W-1:0] addr;
        logic [XW-1:0]     x0;
        logic [XW-1:0]     x1;
        logic [YW-1:0]     y0;
        logic [YW-1:0]     y1;
    } pfde_op_t;

    typedef struct packed {
        logic init_busy;
    } pfde_status_t;

endpackage

>>> rtl/page_framebuffer_draw_engine.sv
// Top level of the page frame store draw engine: configuration registers,
// geometry and the front, queue and back instances. Depends on pfde_pkg.
//
//  channel | direction | ports                         | payload
//  --------+-----------+-------------------------------+----------------------------
//  s_      | in        | s_tvalid s_tready s_tuser/data| one drawing command
//  m_      | out       | m_tvalid m_tready m_tdata     | read_data, in_range
//  cfg_    | in        | cfg_valid cfg_ready           | cfg_index, cfg_data
//
// In the back end a pixel command reads, modifies and writes its byte, then
// gives its result; a bitmap reads its eight bytes in turn and rewrites those its
// mask selects; a rectangle rewrites each touched store byte, and clear and invert
// each active byte. After reset the back end clears the store, MAX_WIDTH*MAX_PAGES
// bytes, and s_tready stays low meanwhile. The two-entry queue lets the front
// accept while the back end works or a stalled result holds it, until it is full.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_PAGES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x[15:0], y[31:16], x_len[39:32], y_len[47:40], color[48],
    // bitmap_byte[56:49], bit_count[60:57], byte_index[70:61]
    input  logic [71:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], in_range[8]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [8:0] MAXW = 9'(MAX_WIDTH);
    localparam logic [7:0] MAXH = 8'(MAX_PAGES * 8);

    logic [7:0] fw_reg;
    logic [6:0] fh_reg;
    logic [8:0] w_eff;
    logic [7:0] h_eff;
    logic [4:0] pages;
    logic [13:0] act;
    pfde_pkg::pfde_geom_t   geom;
    pfde_pkg::pfde_status_t status;
    pfde_pkg::pfde_op_t     q_in, q_head;
    logic q_push, q_pop, q_not_full, q_not_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 8'd128;
            fh_reg <= 7'd64;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pfde_pkg::REG_WIDTH:  fw_reg <= cfg_data;
                pfde_pkg::REG_HEIGHT: fh_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = ({1'b0, fw_reg} > MAXW) ? MAXW : {1'b0, fw_reg};
        h_eff = ({1'b0, fh_reg} > MAXH) ? MAXH : {1'b0, fh_reg};
        pages = 5'((9'(h_eff) + 9'd7) >> 3);
        act   = 14'(w_eff) * 14'(pages);
        geom.w      = w_eff;
        geom.h      = h_eff;
        geom.active = act[pfde_pkg::ACT_W-1:0];
    end

    pfde_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .geom     (geom),
        .status   (status),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    pfde_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    pfde_back #(
        .DEPTH (MAX_WIDTH * MAX_PAGES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .geom     (geom),
        .q_valid  (q_not_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/pfde_front.sv
// Front end: accepts commands, checks ranges, clips rectangles and works out
// store addresses. Depends on pfde_pkg.
`timescale 1ns / 1ps
module pfde_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,
    input  logic [2:0]           s_tuser,
    input  pfde_pkg::pfde_geom_t geom,
    input  pfde_pkg::pfde_status_t status,
    input  logic                 q_ready,
    output logic                 q_push,
    output pfde_pkg::pfde_op_t   q_entry
);

    logic signed [17:0] xs, ys, xe, ye, ws, hs, x0, x1, y0, y1, xi;
    logic [7:0]  x_len, y_len, bits;
    logic [3:0]  cnt, n;
    logic [9:0]  bidx;
    logic        in_xy, y_ok, is_rect;
    logic [3:0]  pg_src;
    logic [12:0] prod;

    assign s_tready = q_ready && !status.init_busy;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        xs    = 18'($signed(s_tdata[15:0]));
        ys    = 18'($signed(s_tdata[31:16]));
        x_len = s_tdata[39:32];
        y_len = s_tdata[47:40];
        bits  = s_tdata[56:49];
        cnt   = s_tdata[60:57];
        bidx  = s_tdata[70:61];
        ws    = $signed({9'b0, geom.w});
        hs    = $signed({10'b0, geom.h});
        xe    = xs + $signed({10'b0, x_len});
        ye    = ys + $signed({10'b0, y_len});
        y_ok  = (ys >= 18'sd0) && (ys < hs);
        in_xy = (xs >= 18'sd0) && (xs < ws) && y_ok;
        x0    = (xs < 18'sd0) ? 18'sd0 : xs;
        y0    = (ys < 18'sd0) ? 18'sd0 : ys;
        x1    = (xe > ws - 18'sd1) ? ws - 18'sd1 : xe;
        y1    = (ye > hs - 18'sd1) ? hs - 18'sd1 : ye;
        n     = (cnt > 4'd8) ? 4'd8 : cnt;
        is_rect = (s_tuser == pfde_pkg::CMD_FILL) || (s_tuser == pfde_pkg::CMD_OUTLINE);
        // One page-times-width product serves pixels, bitmaps and rectangles.
        pg_src = is_rect ? y0[6:3] : ys[6:3];
        prod   = 13'(pg_src) * 13'(geom.w);

        q_entry          = '0;
        q_entry.cmd      = s_tuser;
        q_entry.color    = s_tdata[48];
        q_entry.empty    = (x0 > x1) || (y0 > y1);
        q_entry.left_on  = (xs >= 18'sd0);
        q_entry.right_on = (xe <= ws - 18'sd1);
        q_entry.top_on   = (ys >= 18'sd0);
        q_entry.bot_on   = (ye <= hs - 18'sd1);
        q_entry.bit_sel  = ys[2:0];
        q_entry.x0       = x0[pfde_pkg::XW-1:0];
        q_entry.x1       = x1[pfde_pkg::XW-1:0];
        q_entry.y0       = y0[pfde_pkg::YW-1:0];
        q_entry.y1       = y1[pfde_pkg::YW-1:0];
        for (int i = 0; i < 8; i++) begin
            xi = xs + 18'(i);
            q_entry.bm_mask[i] = bits[7-i] && (4'(i) < n) && (xi >= 18'sd0) && (xi < ws)
                                 && y_ok;
        end
        case (s_tuser)
            pfde_pkg::CMD_CLEAR, pfde_pkg::CMD_INVERT: begin
                q_entry.ok   = 1'b1;
                q_entry.addr = '0;
            end
            pfde_pkg::CMD_RD_BYTE: begin
                q_entry.ok   = {3'b0, bidx} < geom.active;
                q_entry.addr = {2'b0, bidx};
            end
            pfde_pkg::CMD_FILL, pfde_pkg::CMD_OUTLINE: begin
                q_entry.ok   = in_xy;
                q_entry.addr = prod[pfde_pkg::ADDR_W-1:0];
            end
            default: begin
                q_entry.ok   = in_xy;
                q_entry.addr = prod[pfde_pkg::ADDR_W-1:0] + s_tdata[11:0];
            end
        endcase
    end

endmodule

>>> rtl/pfde_queue.sv
// Two-entry queue of decoded commands between front and back end.
// Depends on pfde_pkg.
`timescale 1ns / 1ps
module pfde_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pfde_pkg::pfde_op_t push_entry,
    output logic               not_full,
    input  logic               pop,
    output logic               not_empty,
    output pfde_pkg::pfde_op_t head
);

    pfde_pkg::pfde_op_t ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign not_full  = (cnt_reg != 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> rtl/pfde_back.sv
// Back end: holds the frame store and carries out each command byte by byte,
// then presents the result in an output register. Depends on pfde_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "page_framebuffer_draw_engine_assert.svh"
module pfde_back #(
    parameter int DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfde_pkg::pfde_geom_t  geom,
    input  logic                  q_valid,
    input  pfde_pkg::pfde_op_t    q_head,
    output logic                  q_pop,
    output pfde_pkg::pfde_status_t status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata
);

    localparam int MAW = $clog2(DEPTH);
    localparam logic [pfde_pkg::ADDR_W-1:0] LAST_ADDR = pfde_pkg::ADDR_W'(DEPTH - 1);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_PIX  = 3'd2;
    localparam logic [2:0] ST_RECT = 3'd3;
    localparam logic [2:0] ST_BM   = 3'd4;
    localparam logic [2:0] ST_WALK = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    logic [2:0] st_reg, st_next;
    pfde_pkg::pfde_op_t op_reg, op_next;
    logic [pfde_pkg::ADDR_W-1:0] walk_reg, walk_next, base_reg, base_next;
    logic [pfde_pkg::XW-1:0] px_reg, px_next;
    logic [3:0] pg_reg, pg_next;
    logic [2:0] bi_reg, bi_next;
    logic [7:0] res_data_reg, res_data_next;
    logic       res_ok_reg, res_ok_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [8:0] m_data_reg, m_data_next;

    logic                        mem_re, mem_we;
    logic [pfde_pkg::ADDR_W-1:0] mem_ra, mem_wa;
    logic [7:0]                  mem_wd;

    logic [7:0] pix_m, row_mask, range_mask, d;
    logic [2:0] lo, hi;
    logic       last_col, first_pg, last_pg, edge_col;
    logic [pfde_pkg::ADDR_W-1:0] bump;

    assign status.init_busy = (st_reg == ST_INIT);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    always_comb begin
        st_next       = st_reg;
        op_next       = op_reg;
        walk_next     = walk_reg;
        base_next     = base_reg;
        px_next       = px_reg;
        pg_next       = pg_reg;
        bi_next       = bi_reg;
        res_data_next = res_data_reg;
        res_ok_next   = res_ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        q_pop  = 1'b0;
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_ra = '0;
        mem_wa = '0;
        mem_wd = '0;
        d      = rd_data_reg;
        pix_m  = 8'(1) << op_reg.bit_sel;

        first_pg = (pg_reg == op_reg.y0[6:3]);
        last_pg  = (pg_reg == op_reg.y1[6:3]);
        last_col = (px_reg == op_reg.x1);
        lo = first_pg ? op_reg.y0[2:0] : 3'd0;
        hi = last_pg  ? op_reg.y1[2:0] : 3'd7;
        range_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
        edge_col = (op_reg.cmd == pfde_pkg::CMD_FILL) ||
                   (op_reg.left_on && px_reg == op_reg.x0) ||
                   (op_reg.right_on && last_col);
        // Between an outline's sides only its top and bottom rows are drawn.
        row_mask = edge_col ? range_mask :
                   (((op_reg.top_on && first_pg) ? 8'(1) << op_reg.y0[2:0] : 8'h00) |
                    ((op_reg.bot_on && last_pg) ? 8'(1) << op_reg.y1[2:0] : 8'h00));
        bump = base_reg + pfde_pkg::ADDR_W'(geom.w);

        unique case (st_reg)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wa = walk_reg;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_ADDR) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    op_next       = q_head;
                    res_data_next = 8'h00;
                    res_ok_next   = q_head.ok;
                    case (q_head.cmd)
                        pfde_pkg::CMD_FILL, pfde_pkg::CMD_OUTLINE: begin
                            if (q_head.empty) begin
                                st_next = ST_FIN;
                            end else begin
                                px_next   = q_head.x0;
                                pg_next   = q_head.y0[6:3];
                                base_next = q_head.addr;
                                mem_re    = 1'b1;
                                mem_ra    = q_head.addr + pfde_pkg::ADDR_W'(q_head.x0);
                                st_next   = ST_RECT;
                            end
                        end
                        pfde_pkg::CMD_BITMAP: begin
                            bi_next = 3'd0;
                            mem_re  = 1'b1;
                            mem_ra  = q_head.addr;
                            st_next = ST_BM;
                        end
                        pfde_pkg::CMD_CLEAR, pfde_pkg::CMD_INVERT: begin
                            walk_next = '0;
                            if (geom.active == '0) begin
                                st_next = ST_FIN;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = '0;
                                st_next = ST_WALK;
                            end
                        end
                        default: begin
                            if (q_head.ok) begin
                                mem_re  = 1'b1;
                                mem_ra  = q_head.addr;
                                st_next = ST_PIX;
                            end else begin
                                st_next = ST_FIN;
                            end
                        end
                    endcase
                end
            end
            ST_PIX: begin
                case (op_reg.cmd)
                    pfde_pkg::CMD_PIXEL: begin
                        mem_we = 1'b1;
                        mem_wa = op_reg.addr;
                        mem_wd = op_reg.color ? (d | pix_m) : (d & ~pix_m);
                    end
                    pfde_pkg::CMD_RD_PIXEL: res_data_next = {7'b0, d[op_reg.bit_sel]};
                    default:                res_data_next = d;
                endcase
                st_next = ST_FIN;
            end
            ST_RECT: begin
                mem_we = 1'b1;
                mem_wa = base_reg + pfde_pkg::ADDR_W'(px_reg);
                mem_wd = op_reg.color ? (d | row_mask) : (d & ~row_mask);
                if (last_col && last_pg) begin
                    st_next = ST_FIN;
                end else begin
                    // Read the next byte while this one is written back.
                    mem_re = 1'b1;
                    if (last_col) begin
                        px_next   = op_reg.x0;
                        pg_next   = pg_reg + 1'b1;
                        base_next = bump;
                        mem_ra    = bump + pfde_pkg::ADDR_W'(op_reg.x0);
                    end else begin
                        px_next = px_reg + 1'b1;
                        mem_ra  = base_reg + pfde_pkg::ADDR_W'(px_reg) + 1'b1;
                    end
                end
            end
            ST_BM: begin
                mem_we = op_reg.bm_mask[bi_reg];
                mem_wa = op_reg.addr + pfde_pkg::ADDR_W'(bi_reg);
                mem_wd = op_reg.color ? (d | pix_m) : (d & ~pix_m);
                if (bi_reg == 3'd7) begin
                    st_next = ST_FIN;
                end else begin
                    bi_next = bi_reg + 1'b1;
                    mem_re  = 1'b1;
                    mem_ra  = op_reg.addr + pfde_pkg::ADDR_W'(bi_reg) + 1'b1;
                end
            end
            ST_WALK: begin
                mem_we = 1'b1;
                mem_wa = walk_reg;
                mem_wd = (op_reg.cmd == pfde_pkg::CMD_CLEAR) ? 8'h00 : ~d;
                if ({1'b0, walk_reg} == geom.active - 1'b1) begin
                    st_next = ST_FIN;
                end else begin
                    walk_next = walk_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_ra    = walk_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {res_ok_reg, res_data_reg};
                    st_next       = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_INIT;
            walk_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            walk_reg     <= walk_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        base_reg     <= base_next;
        px_reg       <= px_next;
        pg_reg       <= pg_next;
        bi_reg       <= bi_next;
        res_data_reg <= res_data_next;
        res_ok_reg   <= res_ok_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa[MAW-1:0]] <= mem_wd;
        if (mem_re) rd_data_reg <= mem[mem_ra[MAW-1:0]];
    end

    `PFDE_ASSERT_IMP(a_init_zero, st_reg == ST_INIT, mem_we && mem_wd == 8'h00, "init pass must write zeros")
    `PFDE_ASSERT_IMP(a_pop_idle, q_pop, st_reg == ST_IDLE && q_valid, "queue popped outside idle")
    `PFDE_ASSERT_NXT(a_fin_hold, st_reg == ST_FIN && m_tvalid_reg && !m_tready, st_reg == ST_FIN, "result overwrote a waiting transaction")
    `PFDE_ASSERT_IMP(a_no_pop_init, st_reg == ST_INIT, !q_pop, "command taken during init pass")

endmodule
